/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions that are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cal_pkg.sv */
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types and codes for the compacting array list.
// ----------------------------------------------------------------------------
package cal_pkg;

    localparam int DATA_W = 32;

    // Request codes on the input channel.
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_DUMP   = 2'd3
    } t_req;

    // Status codes on the output channel.
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FOUND     = 3'd4,
        ST_ELEMENT   = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    // Per-cell update command from the sequencer.
    typedef struct packed {
        logic load;   // take the request value
        logic wrap;   // take the head cell's value
        logic shift;  // take the upper neighbor's value
    } t_cell_ctl;

endpackage

/* rtl/cal_cell.sv */
// ----------------------------------------------------------------------------
// cal_cell
// One list slot: holds an entry, compares it with the key and moves it.
// ----------------------------------------------------------------------------
module cal_cell import cal_pkg::*; (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_key,
    input  logic signed [DATA_W-1:0] i_next,
    input  logic signed [DATA_W-1:0] i_head,
    input  logic                     i_active,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_hit
);

    logic signed [DATA_W-1:0] r_data;
    logic                     r_hit;

    // Entry update: load wins over wrap, wrap over shift.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_key;
        end else if (i_ctl.wrap) begin
            r_data <= i_head;
        end else if (i_ctl.shift) begin
            r_data <= i_next;
        end
    end

    // Registered match flag, valid only for slots below the count.
    always_ff @(posedge i_clk) begin
        r_hit <= i_active && (r_data == i_key);
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

/* rtl/compacting_array_list_core.sv */
// ----------------------------------------------------------------------------
// compacting_array_list_core
// Unsorted list of signed words held in a row of cells, with insert,
// delete-and-compact, search and dump requests.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  request | in        | i_in_valid / o_in_stall    | i_req_type, i_value
//  result  | out       | o_out_valid / i_out_stall  | o_status, o_position,
//          |           |                            | o_item, o_last
//
// Insert: the request is taken in IDLE and ACT registers the result.
// Delete and search pass through CMP first, which registers all match flags.
// Dump: ACT registers the first element, then DUMP gives one per cycle as the
// cells rotate and the head feeds the output; an empty list ends in ACT. A new
// request is taken only in IDLE. An output stall holds the sequencer.
// Reset clears the count and the control state; entries need no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module compacting_array_list_core import cal_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_req_type,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [2:0]               o_status,
    output logic [5:0]               o_position,
    output logic signed [DATA_W-1:0] o_item,
    output logic                     o_last
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_ACT,
        S_DUMP
    } t_state;

    t_state                   r_state;
    t_req                     r_req;
    logic signed [DATA_W-1:0] r_key;
    logic [CW-1:0]            r_count;
    logic [IW-1:0]            r_idx;
    logic                     r_out_valid;
    t_status                  r_status;
    logic [5:0]               r_pos;
    logic signed [DATA_W-1:0] r_item;
    logic                     r_last;

    logic signed [DATA_W-1:0] w_data [DEPTH];
    t_cell_ctl                w_ctl  [DEPTH];
    logic [DEPTH-1:0]         w_hit;
    logic [DEPTH-1:0]         w_neg;
    logic [DEPTH-1:0]         w_seen;
    logic [DEPTH-1:0]         w_low;
    logic [IW-1:0]            w_first;
    logic                     w_any;
    logic                     w_full;
    logic                     w_free;
    logic                     w_fire;
    logic                     w_do_insert;
    logic                     w_do_delete;
    logic                     w_do_rotate;
    logic                     w_accept;
    t_status                  w_st;
    logic [5:0]               w_pos;
    logic signed [DATA_W-1:0] w_item;
    logic                     w_last;

    // Handshake and shared conditions.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_free     = !r_out_valid || !i_out_stall;
    assign w_fire     = w_free && ((r_state == S_ACT) || (r_state == S_DUMP));
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_any      = |w_hit;

    assign w_do_insert = w_free && (r_state == S_ACT) && (r_req == REQ_INSERT) && !w_full;
    assign w_do_delete = w_free && (r_state == S_ACT) && (r_req == REQ_DELETE) && w_any;
    assign w_do_rotate = w_free && (((r_state == S_ACT) && (r_req == REQ_DUMP)
                                     && (r_count != '0)) || (r_state == S_DUMP));

    // First match: the two's complement isolates the lowest flag, and the
    // OR with it marks every slot at or above the first match.
    assign w_neg  = ~w_hit + DEPTH'(1);
    assign w_low  = w_hit & w_neg;
    assign w_seen = w_hit | w_neg;

    // One-hot to index of the first match.
    always_comb begin
        w_first = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_low[i]) begin
                w_first = w_first | IW'(i);
            end
        end
    end

    // Row of cells with their per-slot controls.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_next;

        if (g == DEPTH - 1) begin : g_end
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end

        assign w_ctl[g].load  = w_do_insert && (CW'(g) == r_count);
        assign w_ctl[g].wrap  = w_do_rotate && (CW'(g) == r_count - CW'(1));
        assign w_ctl[g].shift = (w_do_delete && w_seen[g]) || w_do_rotate;

        cal_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl[g]),
            .i_key    (r_key),
            .i_next   (w_next),
            .i_head   (w_data[0]),
            .i_active (CW'(g) < r_count),
            .o_data   (w_data[g]),
            .o_hit    (w_hit[g])
        );
    end

    // Result of the current step.
    always_comb begin
        w_st   = ST_ELEMENT;
        w_pos  = '0;
        w_item = r_key;
        w_last = 1'b1;
        if (r_state == S_DUMP) begin
            w_pos  = 6'(r_idx);
            w_item = w_data[0];
            w_last = (CW'(r_idx) + CW'(1) == r_count);
        end else begin
            case (r_req)
                REQ_INSERT: begin
                    w_st = w_full ? ST_FULL : ST_INSERTED;
                end
                REQ_DELETE: begin
                    w_st = w_any ? ST_DELETED : ST_NOT_FOUND;
                end
                REQ_SEARCH: begin
                    w_st  = w_any ? ST_FOUND : ST_NOT_FOUND;
                    w_pos = w_any ? 6'(w_first) : 6'd0;
                end
                REQ_DUMP: begin
                    if (r_count == '0) begin
                        w_st   = ST_EMPTY;
                        w_item = '0;
                    end else begin
                        w_item = w_data[0];
                        w_last = (r_count == CW'(1));
                    end
                end
                default: begin
                    w_st = ST_NOT_FOUND;
                end
            endcase
        end
    end

    // Sequencer, count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_status    <= w_st;
                r_pos       <= w_pos;
                r_item      <= w_item;
                r_last      <= w_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req <= t_req'(i_req_type);
                        r_key <= i_value;
                        if (t_req'(i_req_type) inside {REQ_DELETE, REQ_SEARCH}) begin
                            r_state <= S_CMP;
                        end else begin
                            r_state <= S_ACT;
                        end
                    end
                end
                S_CMP: begin
                    r_state <= S_ACT;
                end
                S_ACT: begin
                    if (w_free) begin
                        if (w_do_insert) begin
                            r_count <= r_count + CW'(1);
                        end
                        if (w_do_delete) begin
                            r_count <= r_count - CW'(1);
                        end
                        r_idx <= IW'(1);
                        if ((r_req == REQ_DUMP) && !w_last) begin
                            r_state <= S_DUMP;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DUMP: begin
                    if (w_free) begin
                        r_idx <= r_idx + IW'(1);
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_position  = r_pos;
    assign o_item      = r_item;
    assign o_last      = r_last;

    // Checks on the list bookkeeping.
    `ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH),
                 "count above depth")
    `ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, w_fire && (w_st == ST_INSERTED),
                 r_count == $past(r_count) + CW'(1), "insert did not grow the list")
    `ASSERT_NEXT(a_delete_count, i_clk, i_rst_n, w_fire && (w_st == ST_DELETED),
                 r_count == $past(r_count) - CW'(1), "delete did not shrink the list")
    `ASSERT_SAME(a_dump_index, i_clk, i_rst_n, r_state == S_DUMP, CW'(r_idx) < r_count,
                 "dump index beyond the list")

endmodule

/* tb/sv/tb_compacting_array_list_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_compacting_array_list_core
// Self-checking bench for the compacting array list. A queue of requests
// (a directed opening, then random fill, drain and mixed stretches) feeds a
// clocked driver. A shadow list predicts every result, and a clocked monitor
// compares each result transfer with the oldest prediction. Both channels
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_compacting_array_list_core;
    import cal_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int REQ_TARGET  = 290;
    localparam int FLUSH_WAIT  = 16;

    // One request as queued for the driver.
    typedef struct packed {
        t_req              kind;
        logic signed [31:0] value;
    } t_list_req;

    // One predicted result.
    typedef struct {
        t_status            status;
        logic [5:0]         position;
        logic signed [31:0] item;
        logic               last;
    } t_list_answer;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} t_mix_mode;

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    t_req               in_req_type = REQ_INSERT;
    logic signed [31:0] in_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         out_status;
    logic [5:0]         out_position;
    logic signed [31:0] out_item;
    logic               out_last;

    t_list_req          pending_reqs[$];
    t_list_answer       list_answers_q[$];
    logic signed [31:0] inserted_history[$];

    // Shadow copy of the list contents.
    logic signed [31:0] held_words [LIST_DEPTH];
    logic [6:0]         held_count = '0;

    int  total_reqs = 0;
    int  reqs_taken = 0;
    int  results_seen = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  calm_left = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    bit  req_took = 1'b0;

    compacting_array_list_core #(
        .DEPTH(LIST_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_req_type  (in_req_type),
        .i_value     (in_value),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (out_status),
        .o_position  (out_position),
        .o_item      (out_item),
        .o_last      (out_last)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Gap lengths: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Values lean on small numbers, extremes and earlier inserts so that
    // duplicates and matches are common.
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30 && inserted_history.size() > 0)
            return inserted_history[$urandom_range(0, inserted_history.size() - 1)];
        if (r < 50) return $signed($urandom_range(0, 7)) - 3;
        if (r < 60) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Delete and search targets mostly name a value that was inserted.
    function automatic logic signed [31:0] pick_target();
        if (inserted_history.size() > 0 && $urandom_range(0, 99) < 65)
            return inserted_history[$urandom_range(0, inserted_history.size() - 1)];
        return pick_value();
    endfunction

    function automatic t_req pick_kind(t_mix_mode mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  return (r < 70) ? REQ_INSERT : (r < 80) ? REQ_DELETE :
                               (r < 92) ? REQ_SEARCH : REQ_DUMP;
            MODE_DRAIN: return (r < 10) ? REQ_INSERT : (r < 80) ? REQ_DELETE :
                               (r < 92) ? REQ_SEARCH : REQ_DUMP;
            default:    return (r < 35) ? REQ_INSERT : (r < 65) ? REQ_DELETE :
                               (r < 92) ? REQ_SEARCH : REQ_DUMP;
        endcase
    endfunction

    function automatic void queue_req(t_req kind, logic signed [31:0] value);
        t_list_req r;
        r.kind  = kind;
        r.value = value;
        pending_reqs.push_back(r);
        if (kind == REQ_INSERT) begin
            inserted_history.push_back(value);
            if (inserted_history.size() > LIST_DEPTH) void'(inserted_history.pop_front());
        end
    endfunction

    function automatic void post_answer(t_status st, logic [5:0] pos,
                                        logic signed [31:0] item, logic last);
        t_list_answer a;
        a.status   = st;
        a.position = pos;
        a.item     = item;
        a.last     = last;
        list_answers_q.push_back(a);
    endfunction

    // Shadow list update and result prediction for one accepted request.
    function automatic void apply_list_request(t_req kind, logic signed [31:0] v);
        int hit;
        hit = -1;
        for (int k = 0; k < held_count; k++) begin
            if (hit < 0 && held_words[k] == v) hit = k;
        end
        case (kind)
            REQ_INSERT: begin
                if (held_count < LIST_DEPTH) begin
                    held_words[held_count] = v;
                    held_count++;
                    post_answer(ST_INSERTED, '0, v, 1'b1);
                end else begin
                    post_answer(ST_FULL, '0, v, 1'b1);
                end
            end
            REQ_DELETE: begin
                if (hit >= 0) begin
                    // Close the gap by moving later entries down one place.
                    for (int k = hit; k + 1 < held_count; k++)
                        held_words[k] = held_words[k + 1];
                    held_count--;
                    post_answer(ST_DELETED, '0, v, 1'b1);
                end else begin
                    post_answer(ST_NOT_FOUND, '0, v, 1'b1);
                end
            end
            REQ_SEARCH: begin
                if (hit >= 0) post_answer(ST_FOUND, hit[5:0], v, 1'b1);
                else          post_answer(ST_NOT_FOUND, '0, v, 1'b1);
            end
            default: begin
                if (held_count == 0) begin
                    post_answer(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    for (int k = 0; k < held_count; k++)
                        post_answer(ST_ELEMENT, k[5:0], held_words[k], k + 1 == held_count);
                end
            end
        endcase
    endfunction

    // Stimulus, reset and end of run.
    initial begin
        t_mix_mode mode;
        int        seg_len;

        // Directed opening: empty list, extremes, duplicates, compaction.
        queue_req(REQ_DUMP,   32'shDEAD_BEEF);
        queue_req(REQ_DELETE, 32'sd5);
        queue_req(REQ_SEARCH, 32'sd5);
        queue_req(REQ_INSERT, 32'sh8000_0000);
        queue_req(REQ_INSERT, 32'sh7FFF_FFFF);
        queue_req(REQ_INSERT, -32'sd1);
        queue_req(REQ_INSERT, 32'sd0);
        queue_req(REQ_INSERT, -32'sd1);
        queue_req(REQ_SEARCH, -32'sd1);
        queue_req(REQ_SEARCH, 32'sh7FFF_FFFF);
        queue_req(REQ_SEARCH, 32'sh8000_0000);
        queue_req(REQ_DUMP,   32'sd0);
        queue_req(REQ_DELETE, -32'sd1);
        queue_req(REQ_SEARCH, -32'sd1);
        queue_req(REQ_DELETE, 32'sh8000_0000);
        queue_req(REQ_DELETE, 32'sh1234_5678);
        queue_req(REQ_SEARCH, 32'sd0);
        queue_req(REQ_DUMP,   32'sh5555_5555);
        queue_req(REQ_DELETE, -32'sd1);
        queue_req(REQ_INSERT, 32'sh5555_5555);
        queue_req(REQ_INSERT, 32'shAAAA_AAAA);
        queue_req(REQ_DUMP,   -32'sd1);

        // Fill burst: enough inserts to reach a full list and overflow it.
        repeat (70) queue_req(REQ_INSERT, pick_value());
        queue_req(REQ_DUMP, $urandom);
        queue_req(REQ_SEARCH, pick_target());

        // Random stretches biased toward filling, draining or mixing.
        while (pending_reqs.size() < REQ_TARGET) begin
            mode    = t_mix_mode'($urandom_range(0, 2));
            seg_len = $urandom_range(10, 40);
            repeat (seg_len) begin
                t_req kind;
                kind = pick_kind(mode);
                if (kind == REQ_DELETE || kind == REQ_SEARCH) queue_req(kind, pick_target());
                else queue_req(kind, (kind == REQ_DUMP) ? $urandom : pick_value());
            end
        end
        queue_req(REQ_DUMP, $urandom);
        total_reqs = pending_reqs.size();

        // Synchronous reset, released on a falling clock edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        while (reqs_taken < total_reqs) @(posedge i_clk);
        while (list_answers_q.size() != 0) @(posedge i_clk);
        repeat (FLUSH_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Request driver: holds a stalled transfer, then idles or sends the next.
    always @(negedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !req_took) begin
            // Transfer still pending; payload stays put.
        end else if (send_gap > 0) begin
            in_valid <= 1'b0;
            send_gap = send_gap - 1;
        end else if (pending_reqs.size() > 0) begin
            t_list_req r;
            r = pending_reqs.pop_front();
            in_req_type <= r.kind;
            in_value    <= r.value;
            in_valid    <= 1'b1;
            send_gap = pick_gap();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Result stall: calm runs and stall runs, plus one long hold-off.
    always @(negedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (!long_hold_done && results_seen >= 50) begin
                long_hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end else if (calm_left > 0) begin
                out_stall <= 1'b0;
                calm_left = calm_left - 1;
            end else begin
                out_stall <= 1'b0;
                calm_left = ($urandom_range(0, 99) < 10) ? $urandom_range(40, 100)
                                                          : $urandom_range(0, 12);
                hold_left = pick_gap();
            end
        end
    end

    // Monitor and predictor: check result transfers, then record requests.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (rst_n) begin
            if (out_valid && !out_stall) begin
                results_seen <= results_seen + 1;
                if (list_answers_q.size() == 0) begin
                    $error("unexpected result: status %0d position %0d item %0d last %0d",
                           out_status, out_position, out_item, out_last);
                    fail_count++;
                end else begin
                    t_list_answer a;
                    a = list_answers_q.pop_front();
                    if (out_status !== a.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               a.status, out_status);
                        fail_count++;
                    end
                    if (out_position !== a.position) begin
                        $error("position mismatch: expected %0d, actual %0d",
                               a.position, out_position);
                        fail_count++;
                    end
                    if (out_item !== a.item) begin
                        $error("item mismatch: expected %0d, actual %0d", a.item, out_item);
                        fail_count++;
                    end
                    if (out_last !== a.last) begin
                        $error("last mismatch: expected %0d, actual %0d", a.last, out_last);
                        fail_count++;
                    end
                end
            end
            req_took <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                reqs_taken <= reqs_taken + 1;
                apply_list_request(in_req_type, in_value);
            end
        end else begin
            req_took <= 1'b0;
        end
    end

endmodule

/* files.f */
+incdir+rtl
rtl/cal_pkg.sv
rtl/cal_cell.sv
rtl/compacting_array_list_core.sv
tb/sv/tb_compacting_array_list_core.sv
